// ===== hw/rtl/gd2c_pkg.sv =====
// shared types and constants for the distance-2 coloring core
package gd2c_pkg;

	localparam int ROW_COUNT_DEF = 64;
	localparam int COL_COUNT_DEF = 64;
	localparam int IDX_W         = 6;
	localparam int COLOR_W       = 6;
	localparam int COLOR_SLOTS   = 64;
	localparam int COUNT_W       = 7;
	localparam int CHUNK_W       = 8;
	localparam int CHUNK_SEL_W   = 3;

	typedef enum logic [1:0] {
		CMD_LOAD_EDGE  = 2'd0,
		CMD_COLOR      = 2'd1,
		CMD_CLR_COLORS = 2'd2,
		CMD_CLR_ALL    = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_EDGE_RD,
		ST_EDGE_WR,
		ST_OWN_RD,
		ST_ROW_SCAN,
		ST_ROW_DRAIN,
		ST_COL_SCAN,
		ST_COL_DRAIN,
		ST_SEARCH,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic ld_in;
		logic clr_colors;
		logic clr_graph;
		logic clr_acc;
		logic cnt_clr;
		logic cnt_inc;
		logic adj_rd_edge;
		logic adj_rd_own;
		logic adj_rd_scan;
		logic adj_wr;
		logic vc_rd;
		logic srch;
		logic result;
	} ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic edge_ok;
		logic vert_ok;
		logic side;
		logic last_row;
		logic last_vert;
		logic last_chunk;
		logic found;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/gd2c_ctrl.sv =====
// sequencing state machine for the coloring core
module gd2c_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gd2c_pkg::sts_t   sts,
	output gd2c_pkg::ctl_t   ctl
);

	gd2c_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gd2c_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gd2c_pkg::ST_IDLE: begin
				if (in_valid) state_d = gd2c_pkg::ST_DISPATCH;
			end
			gd2c_pkg::ST_DISPATCH: begin
				case (sts.cmd)
					gd2c_pkg::CMD_LOAD_EDGE:
						state_d = sts.edge_ok ? gd2c_pkg::ST_EDGE_RD : gd2c_pkg::ST_IDLE;
					gd2c_pkg::CMD_COLOR: begin
						if (!sts.vert_ok) state_d = gd2c_pkg::ST_IDLE;
						else if (sts.side) state_d = gd2c_pkg::ST_OWN_RD;
						else state_d = gd2c_pkg::ST_ROW_SCAN;
					end
					default: state_d = gd2c_pkg::ST_IDLE;
				endcase
			end
			gd2c_pkg::ST_EDGE_RD:   state_d = gd2c_pkg::ST_EDGE_WR;
			gd2c_pkg::ST_EDGE_WR:   state_d = gd2c_pkg::ST_IDLE;
			gd2c_pkg::ST_OWN_RD:    state_d = gd2c_pkg::ST_ROW_SCAN;
			gd2c_pkg::ST_ROW_SCAN: begin
				if (sts.last_row) state_d = gd2c_pkg::ST_ROW_DRAIN;
			end
			gd2c_pkg::ST_ROW_DRAIN: state_d = gd2c_pkg::ST_COL_SCAN;
			gd2c_pkg::ST_COL_SCAN: begin
				if (sts.last_vert) state_d = gd2c_pkg::ST_COL_DRAIN;
			end
			gd2c_pkg::ST_COL_DRAIN: state_d = gd2c_pkg::ST_SEARCH;
			gd2c_pkg::ST_SEARCH: begin
				if (sts.found || sts.last_chunk) state_d = gd2c_pkg::ST_RESULT;
			end
			gd2c_pkg::ST_RESULT: begin
				if (sts.out_free) state_d = gd2c_pkg::ST_IDLE;
			end
			default: state_d = gd2c_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			gd2c_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				ctl.ld_in = in_valid;
			end
			gd2c_pkg::ST_DISPATCH: begin
				ctl.clr_acc = 1'b1;
				ctl.cnt_clr = 1'b1;
				if (sts.cmd == gd2c_pkg::CMD_CLR_COLORS) ctl.clr_colors = 1'b1;
				if (sts.cmd == gd2c_pkg::CMD_CLR_ALL) begin
					ctl.clr_colors = 1'b1;
					ctl.clr_graph  = 1'b1;
				end
			end
			gd2c_pkg::ST_EDGE_RD: ctl.adj_rd_edge = 1'b1;
			gd2c_pkg::ST_EDGE_WR: ctl.adj_wr = 1'b1;
			gd2c_pkg::ST_OWN_RD:  ctl.adj_rd_own = 1'b1;
			gd2c_pkg::ST_ROW_SCAN: begin
				ctl.adj_rd_scan = 1'b1;
				ctl.cnt_inc     = !sts.last_row;
				ctl.cnt_clr     = sts.last_row;
			end
			gd2c_pkg::ST_COL_SCAN: begin
				ctl.vc_rd   = 1'b1;
				ctl.cnt_inc = !sts.last_vert;
				ctl.cnt_clr = sts.last_vert;
			end
			gd2c_pkg::ST_SEARCH: begin
				ctl.srch    = 1'b1;
				ctl.cnt_inc = 1'b1;
			end
			gd2c_pkg::ST_RESULT: ctl.result = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/gd2c_datapath.sv =====
// adjacency and color memories, neighbor accumulators and result register
module gd2c_datapath #(
	parameter int ROW_COUNT = gd2c_pkg::ROW_COUNT_DEF,
	parameter int COL_COUNT = gd2c_pkg::COL_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gd2c_pkg::ctl_t                ctl,
	output gd2c_pkg::sts_t                sts,
	input  logic [1:0]                    cmd,
	input  logic [gd2c_pkg::IDX_W-1:0]    edge_row,
	input  logic [gd2c_pkg::IDX_W-1:0]    edge_col,
	input  logic [gd2c_pkg::IDX_W-1:0]    target_vertex,
	input  logic                          cfg_valid,
	input  logic                          cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gd2c_pkg::IDX_W-1:0]    colored_vertex,
	output logic [gd2c_pkg::COLOR_W-1:0]  assigned_color,
	output logic [gd2c_pkg::COUNT_W-1:0]  color_count
);

	localparam int VMAX = (ROW_COUNT > COL_COUNT) ? ROW_COUNT : COL_COUNT;
	localparam int RW   = $clog2(ROW_COUNT);
	localparam int CW   = $clog2(COL_COUNT);
	localparam int VW   = $clog2(VMAX);
	localparam int CNTW = (VW > gd2c_pkg::CHUNK_SEL_W) ? VW : gd2c_pkg::CHUNK_SEL_W;
	localparam int CW7  = gd2c_pkg::COUNT_W;

	// latched item and configuration
	gd2c_pkg::cmd_t                 cmd_q;
	logic [gd2c_pkg::IDX_W-1:0]     row_q, col_q, v_q;
	logic                           side_q;
	logic [CNTW-1:0]                cnt_q;

	// adjacency store
	logic [COL_COUNT-1:0] adj_mem [ROW_COUNT];
	logic [ROW_COUNT-1:0] row_valid_q;
	logic [COL_COUNT-1:0] adj_rd_q;
	logic                 adj_rdv_q;
	logic [COL_COUNT-1:0] adj_eff;
	logic [RW-1:0]        adj_addr;

	// color store
	logic [gd2c_pkg::COLOR_W-1:0] vc_mem [VMAX];
	logic [gd2c_pkg::COLOR_W-1:0] vc_rd_q;
	logic [VMAX-1:0]              colored_q;
	logic [CW7-1:0]               used_q;

	logic                 scan_s1, own_s1, cscan_s1;
	logic [RW-1:0]        idx_s1;
	logic [VW-1:0]        cidx_s1;
	logic [COL_COUNT-1:0] own_q;
	logic [VMAX-1:0]      set_q, others;
	logic [gd2c_pkg::COLOR_SLOTS-1:0] forb_q;
	logic [gd2c_pkg::COLOR_W-1:0]     color_q;

	logic [gd2c_pkg::CHUNK_W-1:0]     chunk;
	logic [gd2c_pkg::CHUNK_SEL_W-1:0] pos;
	logic                             found;
	logic [CW7-1:0]                   next_cnt;

	logic                           out_valid_q;
	logic [gd2c_pkg::IDX_W-1:0]     out_v_q;
	logic [gd2c_pkg::COLOR_W-1:0]   out_c_q;
	logic [CW7-1:0]                 out_n_q;

	always_ff @(posedge clk) begin
		if (ctl.ld_in) begin
			cmd_q <= gd2c_pkg::cmd_t'(cmd);
			row_q <= edge_row;
			col_q <= edge_col;
			v_q   <= target_vertex;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= 1'b0;
		end else if (cfg_valid) begin
			side_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.cnt_clr) begin
			cnt_q <= '0;
		end else if (ctl.cnt_inc) begin
			cnt_q <= cnt_q + CNTW'(1);
		end
	end

	// one adjacency read port, shared by edge update, own row and the row scan
	always_comb begin
		if (ctl.adj_rd_scan) adj_addr = cnt_q[RW-1:0];
		else if (ctl.adj_rd_own) adj_addr = v_q[RW-1:0];
		else adj_addr = row_q[RW-1:0];
	end

	assign adj_eff = adj_rdv_q ? adj_rd_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.adj_wr) begin
			adj_mem[row_q[RW-1:0]] <= adj_eff | (COL_COUNT'(1) << col_q[CW-1:0]);
		end
		if (ctl.adj_rd_scan || ctl.adj_rd_own || ctl.adj_rd_edge) begin
			adj_rd_q  <= adj_mem[adj_addr];
			adj_rdv_q <= row_valid_q[adj_addr];
		end
	end

	// rows never written since the last graph clear read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (ctl.clr_graph) begin
			row_valid_q <= '0;
		end else if (ctl.adj_wr) begin
			row_valid_q[row_q[RW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1  <= 1'b0;
			own_s1   <= 1'b0;
			cscan_s1 <= 1'b0;
		end else begin
			scan_s1  <= ctl.adj_rd_scan;
			own_s1   <= ctl.adj_rd_own;
			cscan_s1 <= ctl.vc_rd;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cnt_q[RW-1:0];
		cidx_s1 <= cnt_q[VW-1:0];
		if (own_s1) own_q <= adj_eff;
	end

	// distance-2 neighbor set, one row per cycle
	always_ff @(posedge clk) begin
		if (ctl.clr_acc) begin
			set_q <= '0;
		end else if (scan_s1) begin
			if (!side_q) begin
				if (adj_eff[v_q[CW-1:0]]) set_q <= set_q | VMAX'(adj_eff);
			end else if (|(adj_eff & own_q)) begin
				set_q[VW'(idx_s1)] <= 1'b1;
			end
		end
	end

	assign others = set_q & colored_q & ~(VMAX'(1) << v_q[VW-1:0]);

	always_ff @(posedge clk) begin
		if (ctl.result) vc_mem[v_q[VW-1:0]] <= color_q;
		if (ctl.vc_rd) vc_rd_q <= vc_mem[cnt_q[VW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctl.clr_acc) begin
			forb_q <= '0;
		end else if (cscan_s1 && others[cidx_s1]) begin
			forb_q[vc_rd_q] <= 1'b1;
		end
	end

	// lowest free color, one byte of the forbidden mask per cycle
	assign chunk = forb_q[cnt_q[gd2c_pkg::CHUNK_SEL_W-1:0] * gd2c_pkg::CHUNK_W +:
		gd2c_pkg::CHUNK_W];
	assign found = ~&chunk;

	always_comb begin
		pos = '0;
		for (int i = gd2c_pkg::CHUNK_W - 1; i >= 0; i--) begin
			if (!chunk[i]) pos = gd2c_pkg::CHUNK_SEL_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.srch && (found || sts.last_chunk)) begin
			color_q <= found ? {cnt_q[gd2c_pkg::CHUNK_SEL_W-1:0], pos}
			                 : gd2c_pkg::COLOR_W'(gd2c_pkg::COLOR_SLOTS - 1);
		end
	end

	assign next_cnt = ({1'b0, color_q} + CW7'(1) > used_q) ? {1'b0, color_q} + CW7'(1)
	                                                        : used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colored_q <= '0;
			used_q    <= '0;
		end else if (ctl.clr_colors) begin
			colored_q <= '0;
			used_q    <= '0;
		end else if (ctl.result) begin
			colored_q[v_q[VW-1:0]] <= 1'b1;
			used_q                 <= next_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.result) begin
			out_v_q <= v_q;
			out_c_q <= color_q;
			out_n_q <= next_cnt;
		end
	end

	assign out_valid      = out_valid_q;
	assign colored_vertex = out_v_q;
	assign assigned_color = out_c_q;
	assign color_count    = out_n_q;

	always_comb begin
		sts            = '0;
		sts.cmd        = cmd_q;
		sts.edge_ok    = ({1'b0, row_q} < CW7'(ROW_COUNT)) && ({1'b0, col_q} < CW7'(COL_COUNT));
		sts.vert_ok    = {1'b0, v_q} < (side_q ? CW7'(ROW_COUNT) : CW7'(COL_COUNT));
		sts.side       = side_q;
		sts.last_row   = cnt_q == CNTW'(ROW_COUNT - 1);
		sts.last_vert  = cnt_q == (side_q ? CNTW'(ROW_COUNT - 1) : CNTW'(COL_COUNT - 1));
		sts.last_chunk = cnt_q[gd2c_pkg::CHUNK_SEL_W-1:0] ==
			gd2c_pkg::CHUNK_SEL_W'(gd2c_pkg::COLOR_SLOTS / gd2c_pkg::CHUNK_W - 1);
		sts.found      = found;
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule

// ===== hw/rtl/greedy_distance2_coloring_core.sv =====
// greedy partial distance-2 coloring core, top level
// edge load: dispatch, edge read, edge write; clear commands: dispatch only
// color command: dispatch, own-row read when coloring rows, row scan, row drain,
//   color scan, color drain, search, result; result waits until the output is free
// one item at a time; a finished result waits in the output register
// async reset: no edges (row valid bits cleared), all vertices uncolored, color_side 0
module greedy_distance2_coloring_core #(
	parameter int ROW_COUNT = gd2c_pkg::ROW_COUNT_DEF,
	parameter int COL_COUNT = gd2c_pkg::COL_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    cmd,
	input  logic [gd2c_pkg::IDX_W-1:0]    edge_row,
	input  logic [gd2c_pkg::IDX_W-1:0]    edge_col,
	input  logic [gd2c_pkg::IDX_W-1:0]    target_vertex,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gd2c_pkg::IDX_W-1:0]    colored_vertex,
	output logic [gd2c_pkg::COLOR_W-1:0]  assigned_color,
	output logic [gd2c_pkg::COUNT_W-1:0]  color_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data
);

	gd2c_pkg::ctl_t ctl;
	gd2c_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	gd2c_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	gd2c_datapath #(
		.ROW_COUNT (ROW_COUNT),
		.COL_COUNT (COL_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.cmd            (cmd),
		.edge_row       (edge_row),
		.edge_col       (edge_col),
		.target_vertex  (target_vertex),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.colored_vertex (colored_vertex),
		.assigned_color (assigned_color),
		.color_count    (color_count)
	);

	// busy after every input transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// a new result always lies inside the running color count
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ({1'b0, assigned_color} < color_count))
		else $error("color count below assigned color");

	// no more colors than the mask can hold
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (color_count <= gd2c_pkg::COUNT_W'(gd2c_pkg::COLOR_SLOTS)))
		else $error("color count out of range");

endmodule
